// ----- sv/btt_pkg.sv -----
package btt_pkg;

  // payload words
  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               block_end_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               block_end_out;
  } out_word_t;

  // configuration
  typedef enum logic [1:0] {
    REG_INPUT_GAIN   = 2'd0,
    REG_VOLUME       = 2'd1,
    REG_BASS_LEVEL   = 2'd2,
    REG_TREBLE_LEVEL = 2'd3
  } cfg_idx_t;

  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    logic [7:0] input_gain_percent;
    logic [6:0] volume_percent;
    logic [6:0] bass_level;
    logic [6:0] treble_level;
  } cfg_t;

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 20;  // band accumulators and band outputs
  localparam int S_W      = 18;  // scaled input sample
  localparam int OPND_W   = 21;  // signed operand into the shared unit
  localparam int COEF_W   = 8;   // small unsigned coefficient
  localparam int MUL_A_W  = 29;  // |operand| * coefficient
  localparam int MUL_B_W  = 27;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int RES_W    = 24;  // signed quotient

  // x / 100 == (x * RECIP) >> SHIFT, exact for x < 2^30
  localparam logic [MUL_B_W-1:0] DIV100_RECIP = 27'd85899346;
  localparam int                 DIV100_SHIFT = 33;
  localparam int                 QUOT_W       = PROD_W - DIV100_SHIFT;

  localparam logic [COEF_W-1:0] COEF_TENTH     = 8'd10;  // v/10 as v*10/100
  localparam logic [COEF_W-1:0] COEF_TWENTIETH = 8'd5;   // v/20 as v*5/100
  localparam logic [COEF_W-1:0] LEVEL_BASE     = 8'd50;

  localparam logic signed [RES_W-1:0] SAT_MAX = 24'sd32767;
  localparam logic signed [RES_W-1:0] SAT_MIN = -24'sd32768;

  // operation sequence, each is v * c / 100
  typedef enum logic [2:0] {
    OP_GAIN   = 3'd0,
    OP_BASS   = 3'd1,
    OP_BC     = 3'd2,
    OP_TREBLE = 3'd3,
    OP_TC     = 3'd4,
    OP_VOLUME = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic en;        // unit updates its product register
    logic div_pass;  // multiply by reciprocal instead of coefficient
  } mul_ctl_t;

endpackage

// ----- sv/btt_cfg_regs.sv -----
module btt_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  btt_pkg::cfg_idx_t          cfg_index,
  input  logic [btt_pkg::CFG_DATA_W-1:0] cfg_data,
  output btt_pkg::cfg_t              cfg
);
  import btt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_INPUT_GAIN:   cfg_nxt.input_gain_percent = cfg_data;
        REG_VOLUME:       cfg_nxt.volume_percent     = cfg_data[6:0];
        REG_BASS_LEVEL:   cfg_nxt.bass_level         = cfg_data[6:0];
        REG_TREBLE_LEVEL: cfg_nxt.treble_level       = cfg_data[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_gain_percent <= 8'd100;
      cfg_r.volume_percent     <= 7'd100;
      cfg_r.bass_level         <= 7'd50;
      cfg_r.treble_level       <= 7'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/btt_mul_unit.sv -----
module btt_mul_unit (
  input  logic                              clk,
  input  btt_pkg::mul_ctl_t                 ctl,
  input  logic signed [btt_pkg::OPND_W-1:0] opnd,
  input  logic [btt_pkg::COEF_W-1:0]        coef,
  output logic signed [btt_pkg::RES_W-1:0]  res
);
  import btt_pkg::*;

  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               neg_r, neg_nxt;
  logic [OPND_W-1:0]  opnd_mag;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [QUOT_W-1:0]  quot;
  logic [RES_W-1:0]   quot_ext;

  // magnitude path, sign applied after the divide so it truncates toward zero
  assign opnd_mag = opnd[OPND_W-1] ? OPND_W'(-opnd) : OPND_W'(opnd);

  always_comb begin
    if (ctl.div_pass) begin
      mul_a = prod_r[MUL_A_W-1:0];
      mul_b = DIV100_RECIP;
    end else begin
      mul_a = MUL_A_W'(opnd_mag);
      mul_b = MUL_B_W'(coef);
    end
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    if (ctl.en) begin
      prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
      if (!ctl.div_pass) neg_nxt = opnd[OPND_W-1];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
  end

  assign quot     = prod_r[PROD_W-1:DIV100_SHIFT];
  assign quot_ext = RES_W'(quot);
  assign res      = neg_r ? -$signed(quot_ext) : $signed(quot_ext);

endmodule

// ----- sv/bass_treble_tone_control_core.sv -----
// channel | handshake              | payload
// --------+------------------------+-------------------------------------
// in      | in_valid / in_ready    | in_word  (sample_in, block_end_in)
// out     | out_valid / out_ready  | out_word (sample_out, block_end_out)
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// each sample passes through the accept cycle, six multiply-divide ops of
// two passes each through the single shared multiplier, and the finish cycle
// reset is synchronous active low: accumulators clear, registers load defaults
// the output register holds a finished word while a new sample is taken
// the finish cycle waits while the output register is still full
module bass_treble_tone_control_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  btt_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output btt_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  btt_pkg::cfg_idx_t              cfg_index,
  input  logic [btt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import btt_pkg::*;

  cfg_t     cfg;
  mul_ctl_t mul_ctl;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // sample being worked on
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                       blk_r, blk_nxt;

  // intermediate results and filter state
  logic signed [S_W-1:0]   s_r, s_nxt, s_e;
  logic signed [ACC_W-1:0] bass_r, bass_nxt, bass_e;
  logic signed [ACC_W-1:0] treb_r, treb_nxt, treb_e;
  logic signed [ACC_W-1:0] bc_r, bc_nxt, bc_e;
  logic signed [ACC_W-1:0] tc_r, tc_nxt, tc_e;

  logic signed [RES_W-1:0]  res;
  logic signed [RES_W-1:0]  bass_sum, treb_sum;
  logic signed [OPND_W-1:0] opnd;
  logic [COEF_W-1:0]        coef;
  logic signed [OPND_W-1:0] resid;

  logic   wb_en;
  op_t    wb_op;
  logic   in_acc;
  logic   out_load;

  logic                       out_valid_r, out_valid_nxt;
  out_word_t                  out_word_r, out_word_nxt;
  logic signed [SAMPLE_W-1:0] y_sat;

  btt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btt_mul_unit u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .opnd (opnd),
    .coef (coef),
    .res  (res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
          op_nxt    = OP_GAIN;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (op_r == OP_VOLUME) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_MUL;
          op_nxt    = op_t'(op_r + 3'd1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready         = 1'b0;
    mul_ctl.en       = 1'b0;
    mul_ctl.div_pass = 1'b0;
    out_load         = 1'b0;
    wb_en            = 1'b0;
    wb_op            = op_t'(op_r - 3'd1);
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL: begin
        mul_ctl.en = 1'b1;
        // previous op's quotient lands while this op multiplies
        wb_en      = (op_r != OP_GAIN);
      end
      ST_DIV: begin
        mul_ctl.en       = 1'b1;
        mul_ctl.div_pass = 1'b1;
      end
      ST_FIN: begin
        out_load = !out_valid_r || out_ready;
        wb_en    = 1'b1;
        wb_op    = op_r;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  // write-back of the quotient on the unit output
  assign bass_sum = RES_W'(bass_r) + res;
  assign treb_sum = RES_W'(treb_r) + res;

  always_comb begin
    s_e    = s_r;
    bass_e = bass_r;
    bc_e   = bc_r;
    treb_e = treb_r;
    tc_e   = tc_r;
    if (wb_en) begin
      case (wb_op)
        OP_GAIN:   s_e    = res[S_W-1:0];
        OP_BASS:   bass_e = bass_sum[ACC_W-1:0];
        OP_BC:     bc_e   = res[ACC_W-1:0];
        OP_TREBLE: treb_e = treb_sum[ACC_W-1:0];
        OP_TC:     tc_e   = res[ACC_W-1:0];
        default:   s_e    = s_r;  // volume result goes to the output register
      endcase
    end
  end

  // operand select: every op is opnd * coef / 100
  assign resid = OPND_W'(s_e) - OPND_W'(bass_e);

  always_comb begin
    case (op_r)
      OP_GAIN: begin
        opnd = OPND_W'(x_r);
        coef = cfg.input_gain_percent;
      end
      OP_BASS: begin
        opnd = resid;
        coef = COEF_TENTH;
      end
      OP_BC: begin
        opnd = OPND_W'(bass_e);
        coef = LEVEL_BASE + COEF_W'(cfg.bass_level);
      end
      OP_TREBLE: begin
        opnd = resid - OPND_W'(treb_e);
        coef = COEF_TWENTIETH;
      end
      OP_TC: begin
        opnd = OPND_W'(treb_e);
        coef = LEVEL_BASE + COEF_W'(cfg.treble_level);
      end
      OP_VOLUME: begin
        opnd = OPND_W'(bc_e) + OPND_W'(tc_e);
        coef = COEF_W'(cfg.volume_percent);
      end
      default: begin
        opnd = '0;
        coef = '0;
      end
    endcase
  end

  // saturate final quotient to 16 bits
  always_comb begin
    if (res > SAT_MAX)      y_sat = SAMPLE_W'(SAT_MAX);
    else if (res < SAT_MIN) y_sat = SAMPLE_W'(SAT_MIN);
    else                    y_sat = res[SAMPLE_W-1:0];
  end

  always_comb begin
    x_nxt    = in_acc ? in_word.sample_in : x_r;
    blk_nxt  = in_acc ? in_word.block_end_in : blk_r;
    s_nxt    = s_e;
    bass_nxt = bass_e;
    bc_nxt   = bc_e;
    treb_nxt = treb_e;
    tc_nxt   = tc_e;

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
    out_word_nxt  = out_word_r;
    if (out_load) begin
      out_word_nxt.sample_out    = y_sat;
      out_word_nxt.block_end_out = blk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_GAIN;
      bass_r      <= '0;
      treb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      bass_r      <= bass_nxt;
      treb_r      <= treb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    blk_r      <= blk_nxt;
    s_r        <= s_nxt;
    bc_r       <= bc_nxt;
    tc_r       <= tc_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // a taken sample blocks the input until its word is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a sample is in flight");

  // a new output word only comes out of the finish cycle
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_FIN)
    else $error("output word loaded outside the finish cycle");

  // divide pass is always followed by another op or the finish cycle
  a_div_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> state_r == ST_MUL || state_r == ST_FIN)
    else $error("sequencer left the divide pass unexpectedly");

  // the finish cycle is reached only after the volume op
  a_fin_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> op_r == OP_VOLUME)
    else $error("finish reached before the last op");

endmodule

// ----- verif/btt_tone_checker.sv -----
module btt_tone_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  btt_pkg::in_word_t              in_word,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  btt_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  btt_pkg::cfg_idx_t              cfg_index,
  input  logic [btt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import btt_pkg::*;

  // shadow registers and band state
  logic [7:0]         gain_pct;
  logic [6:0]         volume_pct;
  logic [6:0]         bass_lvl;
  logic [6:0]         treble_lvl;
  logic signed [19:0] bass_acc;
  logic signed [19:0] treble_acc;

  out_word_t expected_words[$];

  // one sample through both bands, updates the band state
  function automatic out_word_t tone_predict(input in_word_t w);
    longint    s, b, t, bc, tc, y;
    out_word_t r;
    s  = longint'($signed(w.sample_in)) * longint'(gain_pct) / 100;
    b  = bass_acc;
    b  = b + (s - b) / 10;
    bc = b * (50 + longint'(bass_lvl)) / 100;
    t  = treble_acc;
    t  = t + ((s - b) - t) / 20;
    tc = t * (50 + longint'(treble_lvl)) / 100;
    y  = (bc + tc) * longint'(volume_pct) / 100;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    bass_acc   = b[19:0];
    treble_acc = t[19:0];
    r.sample_out    = y[15:0];
    r.block_end_out = w.block_end_in;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      gain_pct   = 8'd100;
      volume_pct = 7'd100;
      bass_lvl   = 7'd50;
      treble_lvl = 7'd50;
      bass_acc   = '0;
      treble_acc = '0;
      expected_words.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INPUT_GAIN:   gain_pct   = cfg_data;
          REG_VOLUME:       volume_pct = cfg_data[6:0];
          REG_BASS_LEVEL:   bass_lvl   = cfg_data[6:0];
          REG_TREBLE_LEVEL: treble_lvl = cfg_data[6:0];
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("sample_out: expected none, actual %0d", $signed(out_word.sample_out));
          bad++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, actual %0d",
                   $signed(want.sample_out), $signed(out_word.sample_out));
            bad++;
          end
          if (out_word.block_end_out !== want.block_end_out) begin
            $error("block_end_out: expected %0b, actual %0b",
                   want.block_end_out, out_word.block_end_out);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) expected_words.push_back(tone_predict(in_word));
      fail_count <= fail_count + bad;
      pending    <= expected_words.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import btt_pkg::*;

  localparam int ITEM_CYCLES   = 14;
  localparam int NUM_SAMPLES   = 1650;
  localparam int IDLE_LIMIT    = 4000;

  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word  = '0;

  // result channel
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // register write channel
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = REG_INPUT_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int sent = 0;

  // when set, neither side idles
  bit steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  bass_treble_tone_control_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  btt_tone_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // register value: ends of range often, sometimes any byte to hit masking
  function automatic logic [7:0] pick_reg(input int top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return top[7:0];
    if (r == 2) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, top));
  endfunction

  // one sample word, valid stays up across back-to-back words
  task automatic send_sample(input logic signed [15:0] smp, input logic blk_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{sample_in: smp, block_end_in: blk_end};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // stop sending, let every result drain, then give the core time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 6) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all four registers back to back, valid drops after the last
  task automatic set_config(input logic [7:0] gain, vol, bass, treb);
    cfg_put(REG_INPUT_GAIN, gain);
    cfg_put(REG_VOLUME, vol);
    cfg_put(REG_BASS_LEVEL, bass);
    cfg_put(REG_TREBLE_LEVEL, treb);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls unless steady
  initial begin
    int hold;
    int g;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          hold = g;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [15:0] held;
    int                 phase_len;
    int                 r;
    held = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: extremes and alternating bit patterns
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sh0001, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh5556, 1'b1);

    // full gain and weights: large steps push the output into saturation
    wait_idle();
    set_config(8'd255, 8'd100, 8'd100, 8'd100);
    repeat (4) send_sample(16'sh7FFF, 1'b0);
    repeat (4) send_sample(-16'sh8000, 1'b1);

    // everything zero
    wait_idle();
    set_config(8'd0, 8'd0, 8'd0, 8'd0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sh8000, 1'b0);

    // above stated range and wider than the register, kept as low bits
    wait_idle();
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh1234, 1'b0);

    // random phases with their own settings
    while (sent < NUM_SAMPLES) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      set_config(pick_reg(255), pick_reg(100), pick_reg(100), pick_reg(100));
      phase_len = $urandom_range(40, 200);
      // last phase only tops up to the sample count
      if (phase_len > NUM_SAMPLES - sent) phase_len = NUM_SAMPLES - sent;
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 45) held = 16'($urandom());
        else if (r < 60) held = r[0] ? 16'sh7FFF : -16'sh8000;
        else if (r < 80) held = 16'($signed($urandom_range(0, 400)) - 200);
        // otherwise hold the last value so the bands settle
        send_sample(held, ($urandom_range(0, 7) == 0));
      end
    end

    // drain and settle, then verdict
    wait_idle();
    repeat (2 * ITEM_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
